// ===== sv/mhpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = ADDR_W + 2;

   typedef enum logic {
      KIND_INSERT  = 1'b0,
      KIND_EXTRACT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_EX_RD,
      ST_EX_LD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [KEY_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } mem_req_type;

endpackage
`default_nettype wire

// ===== sv/min_heap_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of signed 32-bit keys, 64 entries, held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers on a clock edge with start high and
//   busy low. req_kind selects insert (req_key_in) or extract minimum.
//   Result channel: rsp_valid strobes for one cycle per item with status,
//   the removed minimum (0 unless a successful extract) and the count after.
//   The receiver cannot stall; each result must be taken in its cycle.
// Sequencing: each sift level is a memory read, then a compare and
//   write-back. An insert sifts its key up from the new leaf; an extract
//   reads the root and the last key, then sifts that key down from the
//   root. A rejected item goes straight to the result strobe.
//   busy stays high from the transfer to the result strobe; the next item
//   can transfer in the cycle after the strobe.
// Reset: synchronous, clears the count and the sequencer; store contents
//   are left as they are and never used above the count.
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_kind,
   input  wire logic signed [mhpq_pkg::KEY_W-1:0] req_key_in,
   output logic                                   rsp_valid,
   output logic             [1:0]                 rsp_status,
   output logic signed      [mhpq_pkg::KEY_W-1:0] rsp_min_out,
   output logic             [mhpq_pkg::CNT_W-1:0] rsp_count_out
);
   import mhpq_pkg::*;

   mem_req_type       mem_req;
   logic [KEY_W-1:0]  rdata_a;
   logic [KEY_W-1:0]  rdata_b;

   mhpq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_key_in    (req_key_in),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_min_out   (rsp_min_out),
      .rsp_count_out (rsp_count_out),
      .mem_req       (mem_req),
      .rdata_a       (rdata_a),
      .rdata_b       (rdata_b)
   );

   mhpq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_W)
   ) u_ram (
      .clock   (clock),
      .we      (mem_req.we),
      .waddr   (mem_req.waddr),
      .wdata   (mem_req.wdata),
      .raddr_a (mem_req.raddr_a),
      .raddr_b (mem_req.raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

endmodule
`default_nettype wire

// ===== sv/mhpq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int  DEPTH = 64,
   parameter int  WIDTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr_a,
   input  wire logic [AW-1:0]    raddr_b,
   output logic      [WIDTH-1:0] rdata_a,
   output logic      [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule
`default_nettype wire

// ===== sv/mhpq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer and datapath: hole-based sift-up and sift-down over the store.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_kind,
   input  wire logic signed [mhpq_pkg::KEY_W-1:0] req_key_in,
   output logic                               rsp_valid,
   output logic             [1:0]             rsp_status,
   output logic signed      [mhpq_pkg::KEY_W-1:0] rsp_min_out,
   output logic             [mhpq_pkg::CNT_W-1:0] rsp_count_out,
   output mhpq_pkg::mem_req_type              mem_req,
   input  wire logic        [mhpq_pkg::KEY_W-1:0] rdata_a,
   input  wire logic        [mhpq_pkg::KEY_W-1:0] rdata_b
);
   import mhpq_pkg::*;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   logic signed [KEY_W-1:0]  min_ff, min_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   status_type               status_ff, status_in;

   logic [ADDR_W-1:0]        parent_idx;
   logic [CHILD_W-1:0]       child_l;
   logic [CHILD_W-1:0]       child_r;
   logic [CHILD_W-1:0]       n_ext;
   logic                     is_full;
   logic                     is_empty;
   logic                     up_move;
   logic                     pick_r;
   logic signed [KEY_W-1:0]  best_key;
   logic [ADDR_W-1:0]        best_idx;
   logic                     dn_move;
   logic                     no_child;

   assign parent_idx = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
   assign child_l    = {1'b0, pos_ff, 1'b1};
   assign child_r    = child_l + CHILD_W'(1);
   assign n_ext      = CHILD_W'(count_ff);
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign no_child   = (child_l >= n_ext);
   assign up_move    = ($signed(rdata_a) > key_ff);
   assign pick_r     = (child_r < n_ext) && ($signed(rdata_a) > $signed(rdata_b));
   assign best_key   = pick_r ? $signed(rdata_b) : $signed(rdata_a);
   assign best_idx   = pick_r ? child_r[ADDR_W-1:0] : child_l[ADDR_W-1:0];
   assign dn_move    = (key_ff > best_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      min_ff    <= min_in;
      status_ff <= status_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (kind_type'(req_kind) == KIND_INSERT) begin
                  state_in = is_full ? ST_RESP : ST_UP_RD;
               end else begin
                  state_in = is_empty ? ST_RESP : ST_EX_RD;
               end
            end
         end
         ST_UP_RD:  state_in = (pos_ff == '0) ? ST_RESP : ST_UP_CMP;
         ST_UP_CMP: state_in = up_move ? ST_UP_RD : ST_RESP;
         ST_EX_RD:  state_in = ST_EX_LD;
         ST_EX_LD:  state_in = is_empty ? ST_RESP : ST_DN_RD;
         ST_DN_RD:  state_in = no_child ? ST_RESP : ST_DN_CMP;
         ST_DN_CMP: state_in = dn_move ? ST_DN_RD : ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      pos_in    = pos_ff;
      key_in    = key_ff;
      min_in    = min_ff;
      count_in  = count_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               min_in    = '0;
               status_in = STATUS_OK;
               if (kind_type'(req_kind) == KIND_INSERT) begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     pos_in   = count_ff[ADDR_W-1:0];
                     key_in   = req_key_in;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         ST_UP_CMP: begin
            if (up_move) begin
               pos_in = parent_idx;
            end
         end
         ST_EX_LD: begin
            min_in = $signed(rdata_a);
            key_in = $signed(rdata_b);
            pos_in = '0;
         end
         ST_DN_CMP: begin
            if (dn_move) begin
               pos_in = best_idx;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      mem_req       = '0;
      busy          = (state_ff != ST_IDLE);
      rsp_valid     = (state_ff == ST_RESP);
      rsp_status    = status_ff;
      rsp_min_out   = min_ff;
      rsp_count_out = count_ff;
      case (state_ff)
         ST_UP_RD: begin
            mem_req.raddr_a = parent_idx;
            if (pos_ff == '0) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pos_ff;
               mem_req.wdata = key_ff;
            end
         end
         ST_UP_CMP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            mem_req.wdata = up_move ? rdata_a : key_ff;
         end
         ST_EX_RD: begin
            mem_req.raddr_a = '0;
            mem_req.raddr_b = count_ff[ADDR_W-1:0];
         end
         ST_DN_RD: begin
            mem_req.raddr_a = child_l[ADDR_W-1:0];
            mem_req.raddr_b = child_r[ADDR_W-1:0];
            if (no_child) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pos_ff;
               mem_req.wdata = key_ff;
            end
         end
         ST_DN_CMP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            mem_req.wdata = dn_move ? best_key : key_ff;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/mhpq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       rsp_valid,
   input wire logic [1:0]                 rsp_status,
   input wire logic [mhpq_pkg::KEY_W-1:0] rsp_min_out,
   input wire logic [mhpq_pkg::CNT_W-1:0] rsp_count_out
);
   import mhpq_pkg::*;

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low after command transfer");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_reject_min_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_min_out == '0)
      else $error("rejected item with nonzero minimum");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_count_out == CNT_W'(CAPACITY))
      else $error("full status with count below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> rsp_count_out == '0)
      else $error("empty status with nonzero count");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_min_out   (rsp_min_out),
   .rsp_count_out (rsp_count_out)
);
`default_nettype wire
